// File: src/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg
// shared widths, codes and record types of the rate monotonic task scheduler
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int CMD_W      = 2;
  localparam int ID_W       = 15;
  localparam int PER_W      = 16;
  localparam int CMP_W      = 16;
  localparam int WGT_W      = 10;
  localparam int TIME_W     = 32;
  localparam int STAT_W     = 3;
  localparam int CNT_OUT_W  = 5;
  localparam int SCALE_W    = 10;
  localparam int DVD_W      = CMP_W + SCALE_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // compute is scaled to thousandths before the divide
  localparam logic [SCALE_W-1:0] MS_SCALE    = 10'd1000;
  localparam logic [WGT_W-1:0]   LIMIT_RESET = 10'd693;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_YIELD      = 2'd1,
    CMD_DEREGISTER = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  // one entry of the task table memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  period;
    logic [WGT_W-1:0]  weight;
    logic [TIME_W-1:0] rel_time;
  } slot_rec_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/rmts_div.sv
// ----------------------------------------------------------------------------
// rmts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rmts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmts_pkg::div_req_t req_i,
  output rmts_pkg::div_rsp_t rsp_o
);
  import rmts_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [PER_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [PER_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [PER_W:0]    rem_sh;
  logic [PER_W:0]    diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    if (!diff[PER_W]) begin
      rem_d = diff[PER_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[PER_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (step_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == STEP_W'(1)) && !req_i.start;
      if (req_i.start) begin
        step_q <= STEP_W'(DVD_W);
      end else if (step_q != '0) begin
        step_q <= step_q - STEP_W'(1);
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: src/rate_monotonic_task_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// rate monotonic task scheduler with utilization admission and a task table
// ----------------------------------------------------------------------------
// each request carries one command in tuser: register, yield, deregister or a
// one millisecond tick, and gives exactly one result. the block walks the
// task table held in a memory, one slot per cycle: a first walk looks up the
// id, finds the lowest free slot and, on a tick, readies every armed task
// whose release has come; a second walk picks the awake task with the
// smallest period (lowest slot on a tie) as the running task.
// a register of a new id with a nonzero period also runs the weight
// floor(compute*1000/period)+1 through a bit-serial divider. the next request
// is taken as soon as the result sits in the output register. the admission
// limit is to be written through the cfg port only while no request is in
// flight; the block itself does not enforce this. a refused register changes
// nothing; ids already in the table are refused.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [14:0] task_id, [30:15] period_ms, [46:31] compute_ms, [47] zero
  input  logic [rmts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] command
  input  logic [rmts_pkg::CMD_W-1:0]         s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] status, [3] running_valid, [18:4] running_id,
  // [28:19] utilization_total, [33:29] task_count, [39:34] zero
  output logic [rmts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // admission limit write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rmts_pkg::WGT_W-1:0]         cfg_data_i
);
  import rmts_pkg::*;

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int WSUM_W = DVD_W + 1;
  localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(MAX_TASKS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_APPLY = 7'b0010000,
    S_DISP  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // latched request
  cmd_e             cmd_q;
  logic [ID_W-1:0]  id_q;
  logic [PER_W-1:0] per_q;
  logic [CMP_W-1:0] cmp_q;
  status_e          status_q;

  // block state
  logic [WGT_W-1:0]     limit_q;
  logic [TIME_W-1:0]    time_q;
  logic [WGT_W-1:0]     wsum_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [MAX_TASKS-1:0] valid_q;
  logic [MAX_TASKS-1:0] armed_q;
  logic [MAX_TASKS-1:0] awake_q;

  // task table memory
  slot_rec_t mem_q [MAX_TASKS];
  slot_rec_t rd_rec_q;
  slot_rec_t wr_rec;
  logic [IDX_W-1:0] rd_addr, wr_addr, rd_idx_q;
  logic             rd_vld_q, mem_we;

  // table walk
  logic [IDX_W:0] scan_cnt_q;
  logic           scanning, issue, scan_done;
  logic           el_valid, el_match, el_free, el_due, el_better;
  logic [TIME_W-1:0] age;

  // lookup results
  logic             found_q, free_found_q;
  logic [IDX_W-1:0] fidx_q, free_idx_q;
  slot_rec_t        frec_q;

  // dispatch results
  logic             best_found_q;
  logic [PER_W-1:0] best_per_q;
  logic [ID_W-1:0]  best_id_q;

  // weight path
  logic [DVD_W-1:0]  prod_q;
  logic              div_start_q;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [WSUM_W-1:0] weight, new_sum;
  logic              over, reg_ok;

  // output register
  logic                  m_tvalid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  logic s_acc, out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_tvalid_q || m_axis_tready;

  // walk control: issue one read per cycle, handle the slot in the cycle after its read
  assign scanning  = (state_q == S_SCAN) || (state_q == S_DISP);
  assign issue     = scanning && (scan_cnt_q != SCAN_END);
  assign rd_addr   = issue ? scan_cnt_q[IDX_W-1:0] : '0;
  assign scan_done = scanning && !issue && !rd_vld_q;

  // per slot decisions on the slot that came back from memory
  assign age       = time_q - rd_rec_q.rel_time;
  assign el_valid  = rd_vld_q && valid_q[rd_idx_q];
  assign el_match  = el_valid && (rd_rec_q.id == id_q);
  assign el_free   = rd_vld_q && !valid_q[rd_idx_q];
  // release reached when the wrapped difference is not negative
  assign el_due    = el_valid && armed_q[rd_idx_q] && !age[TIME_W-1];
  // strict compare keeps the lowest slot on equal periods
  assign el_better = el_valid && awake_q[rd_idx_q] &&
                     (!best_found_q || (rd_rec_q.period < best_per_q));

  // admission check on the divider result
  assign weight  = {1'b0, div_rsp.quotient} + WSUM_W'(1);
  assign new_sum = WSUM_W'(wsum_q) + weight;
  assign over    = new_sum > WSUM_W'(limit_q);
  assign reg_ok  = (cmd_q == CMD_REGISTER) && !over && free_found_q;

  assign div_req.start    = div_start_q;
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = per_q;

  rmts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          case (cmd_q)
            CMD_REGISTER: begin
              state_d = (found_q || (per_q == '0)) ? S_DISP : S_MUL;
            end
            CMD_YIELD, CMD_DEREGISTER: begin
              state_d = found_q ? S_APPLY : S_DISP;
            end
            default: state_d = S_DISP;
          endcase
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_d = S_APPLY;
      end
      S_APPLY: state_d = S_DISP;
      S_DISP: begin
        if (scan_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // table write: new entry on register, new release on yield
  always_comb begin
    mem_we  = (state_q == S_APPLY) && (reg_ok || (cmd_q == CMD_YIELD));
    wr_addr = (cmd_q == CMD_REGISTER) ? free_idx_q : fidx_q;
    wr_rec  = frec_q;
    if (cmd_q == CMD_REGISTER) begin
      wr_rec.id       = id_q;
      wr_rec.period   = per_q;
      wr_rec.weight   = weight[WGT_W-1:0];
      wr_rec.rel_time = time_q;
    end else begin
      wr_rec.rel_time = frec_q.rel_time + TIME_W'(frec_q.period);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_rec;
    rd_rec_q <= mem_q[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      id_q  <= s_axis_tdata[14:0];
      per_q <= s_axis_tdata[30:15];
      cmp_q <= s_axis_tdata[46:31];
    end
    if (state_q == S_SCAN && el_match) begin
      fidx_q <= rd_idx_q;
      frec_q <= rd_rec_q;
    end
    if (state_q == S_SCAN && el_free && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (state_q == S_MUL) begin
      prod_q <= DVD_W'(cmp_q) * DVD_W'(MS_SCALE);
    end
    if (state_q == S_DISP && el_better) begin
      best_per_q <= rd_rec_q.period;
    end
    rd_idx_q <= scan_cnt_q[IDX_W-1:0];
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_REGISTER;
      status_q     <= ST_OK;
      limit_q      <= LIMIT_RESET;
      time_q       <= '0;
      wsum_q       <= '0;
      cnt_q        <= '0;
      valid_q      <= '0;
      armed_q      <= '0;
      awake_q      <= '0;
      scan_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      best_id_q    <= '0;
      div_start_q  <= 1'b0;
      m_tvalid_q   <= 1'b0;
      m_data_q     <= '0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= issue;
      div_start_q <= (state_q == S_MUL);

      if (cfg_valid_i) limit_q <= cfg_data_i;

      if (state_q != state_d) begin
        scan_cnt_q <= '0;
      end else if (issue) begin
        scan_cnt_q <= scan_cnt_q + (IDX_W + 1)'(1);
      end

      if (s_acc) begin
        cmd_q        <= cmd_e'(s_axis_tuser);
        status_q     <= ST_OK;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        if (cmd_e'(s_axis_tuser) == CMD_TICK) time_q <= time_q + TIME_W'(1);
      end

      // first walk: lookup, free slot, releases on a tick
      if (state_q == S_SCAN) begin
        if (el_match) found_q <= 1'b1;
        if (el_free) free_found_q <= 1'b1;
        if (el_due && cmd_q == CMD_TICK) begin
          armed_q[rd_idx_q] <= 1'b0;
          awake_q[rd_idx_q] <= 1'b1;
        end
        if (scan_done) begin
          case (cmd_q)
            CMD_REGISTER: begin
              if (found_q) begin
                status_q <= ST_DUPLICATE;
              end else if (per_q == '0) begin
                status_q <= ST_REFUSED;
              end
            end
            CMD_YIELD, CMD_DEREGISTER: begin
              if (!found_q) status_q <= ST_NOT_FOUND;
            end
            default: status_q <= ST_OK;
          endcase
        end
      end

      if (state_q == S_APPLY) begin
        case (cmd_q)
          CMD_REGISTER: begin
            if (over) begin
              status_q <= ST_REFUSED;
            end else if (!free_found_q) begin
              status_q <= ST_FULL;
            end else begin
              valid_q[free_idx_q] <= 1'b1;
              armed_q[free_idx_q] <= 1'b0;
              awake_q[free_idx_q] <= 1'b0;
              wsum_q              <= new_sum[WGT_W-1:0];
              cnt_q               <= cnt_q + CNT_W'(1);
            end
          end
          CMD_YIELD: begin
            armed_q[fidx_q] <= 1'b1;
            awake_q[fidx_q] <= 1'b0;
          end
          CMD_DEREGISTER: begin
            valid_q[fidx_q] <= 1'b0;
            armed_q[fidx_q] <= 1'b0;
            wsum_q          <= wsum_q - frec_q.weight;
            cnt_q           <= cnt_q - CNT_W'(1);
          end
          default: status_q <= ST_OK;
        endcase
      end

      // second walk: pick the running task
      if (state_d == S_DISP && state_q != S_DISP) begin
        best_found_q <= 1'b0;
        best_id_q    <= '0;
      end else if (state_q == S_DISP && el_better) begin
        best_found_q <= 1'b1;
        best_id_q    <= rd_rec_q.id;
      end

      // result register
      if (state_q == S_FIN && out_free) begin
        m_tvalid_q <= 1'b1;
        m_data_q   <= {6'b0, cnt_ext[CNT_OUT_W-1:0], wsum_q, best_id_q, best_found_q,
                       status_q};
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: src/rmts_checker.sv
// ----------------------------------------------------------------------------
// rmts_checker
// port level checks of the rate monotonic task scheduler
// ----------------------------------------------------------------------------
module rmts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rmts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import rmts_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // no running task means id zero
  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3] || (m_axis_tdata[18:4] == '0)))
    else $error("running id without running task");

  // status code in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= ST_DUPLICATE))
    else $error("bad status code");

endmodule

bind rate_monotonic_task_scheduler rmts_checker u_rmts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
